FILE: design/ewsa_pkg.sv
`timescale 1ns / 1ps

package ewsa_pkg;

   // Depths of the tick ring and of the change ring.
   localparam int TICK_WINDOW  = 8;
   localparam int ACCEL_WINDOW = 8;

   localparam int TICK_IDX_W  = (TICK_WINDOW > 1) ? $clog2(TICK_WINDOW) : 1;
   localparam int ACCEL_IDX_W = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;

   localparam int COUNT_W = 16;
   localparam int SUM_W   = 24;
   localparam int WORD_W  = 32;
   localparam int GAP_W   = 16;
   localparam int CFG_W   = 16;

   // The divider retires this many quotient bits per clock.
   localparam int DIV_BITS_PER_CYCLE = 2;
   localparam int DIV_STEPS          = WORD_W / DIV_BITS_PER_CYCLE;
   localparam int DIV_CNT_W          = $clog2(DIV_STEPS);

   // Configuration register indexes.
   localparam logic [1:0] CSR_TIMER_MODE = 2'd0;
   localparam logic [1:0] CSR_WRAP_THR   = 2'd1;
   localparam logic [1:0] CSR_PERIMETER  = 2'd2;
   localparam logic [1:0] CSR_RATIO      = 2'd3;

   // Request kinds carried on req_tuser.
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [SUM_W-1:0]   sum_type;
   typedef logic [WORD_W-1:0]  word_type;

endpackage

FILE: design/encoder_window_speed_accel.sv
`timescale 1ns / 1ps

// Two-wheel encoder window, speed and acceleration engine. Each transfer on the
// req_ channel is either a sample (req_tuser low) carrying one tick count per
// wheel, or an update (req_tuser high). A sample is absorbed in the cycle it is
// accepted: in timer mode a count above the wrap threshold is replaced by 65536
// minus the count, and both counts enter eight-deep rings whose sums are kept
// up to date. An update produces one rsp_ transfer only if a sample arrived
// since the last update that produced one; otherwise it is dropped silently.
// The result carries both window sums, the speeds (sum times perimeter, kept
// to 32 bits, divided by the ratio; a zero ratio yields all ones), the
// accelerations (wrapping sums of the last eight window-sum changes) and the
// low 16 bits of the left-right sum gap. Speeds come from one shared
// multiplier followed by one shared restoring divider that retires two
// quotient bits per clock, used first for the left and then for the right
// wheel: an acting update passes through ST_MUL and ST_DIV for each wheel
// before rsp_tvalid rises in ST_DONE, which lasts until rsp_tready is high;
// req_tready is low for that whole span. Samples and non-acting updates
// leave the sequencer idle. Configuration writes are always accepted and must
// only be issued while no update is in progress.

module encoder_window_speed_accel
   import ewsa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [15:0] left_count, [31:16] right_count
   input  logic        req_tuser,    // [0] req_type

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [23:0] left_window_sum, [47:24] right_window_sum, [79:48] left_speed,
   // [111:80] right_speed, [143:112] left_accel, [175:144] right_accel,
   // [191:176] sum_gap
   output logic [191:0] rsp_tdata,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Configuration registers.
   logic             timer_mode_ff, timer_mode_in;
   logic [CFG_W-1:0] wrap_thr_ff, wrap_thr_in;
   logic [CFG_W-1:0] perimeter_ff, perimeter_in;
   logic [CFG_W-1:0] ratio_ff, ratio_in;

   // Window state.
   count_type              ltick_ff [TICK_WINDOW];
   count_type              ltick_in [TICK_WINDOW];
   count_type              rtick_ff [TICK_WINDOW];
   count_type              rtick_in [TICK_WINDOW];
   logic [TICK_IDX_W-1:0]  tpos_ff, tpos_in;
   sum_type                lsum_ff, lsum_in;
   sum_type                rsum_ff, rsum_in;
   sum_type                lpub_ff, lpub_in;
   sum_type                rpub_ff, rpub_in;
   word_type               lchg_ff [ACCEL_WINDOW];
   word_type               lchg_in [ACCEL_WINDOW];
   word_type               rchg_ff [ACCEL_WINDOW];
   word_type               rchg_in [ACCEL_WINDOW];
   logic [ACCEL_IDX_W-1:0] cpos_ff, cpos_in;
   word_type               laccel_ff, laccel_in;
   word_type               raccel_ff, raccel_in;
   logic                   pending_ff, pending_in;

   // Sequencer and shared arithmetic.
   logic [1:0]           state_ff, state_in;
   logic                 sel_ff, sel_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   word_type             dvd_ff, dvd_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;

   // Result registers.
   word_type         lspeed_ff, lspeed_in;
   word_type         rspeed_ff, rspeed_in;
   logic [GAP_W-1:0] gap_ff, gap_in;

   logic req_fire;
   logic csr_fire;

   // Timer-mode correction: a count above the threshold is a backward wrap.
   function automatic count_type correct_count(input count_type c, input logic mode,
                                               input count_type thr);
      count_type res;
      res = c;
      if (mode && (c > thr)) begin
         res = count_type'(-c);
      end
      return res;
   endfunction

   assign req_fire   = req_tvalid & req_tready;
   assign csr_fire   = csr_valid & csr_ready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_DONE);

   assign rsp_tdata = {gap_ff, raccel_ff, laccel_ff, rspeed_ff, lspeed_ff, rpub_ff, lpub_ff};

   always_comb begin
      count_type            lc;
      count_type            rc;
      word_type             lchg;
      word_type             rchg;
      sum_type              sel_sum;
      logic [39:0]          prod;
      word_type             d;
      logic [CFG_W-1:0]     r;
      logic [CFG_W:0]       t;

      timer_mode_in = timer_mode_ff;
      wrap_thr_in   = wrap_thr_ff;
      perimeter_in  = perimeter_ff;
      ratio_in      = ratio_ff;
      ltick_in      = ltick_ff;
      rtick_in      = rtick_ff;
      tpos_in       = tpos_ff;
      lsum_in       = lsum_ff;
      rsum_in       = rsum_ff;
      lpub_in       = lpub_ff;
      rpub_in       = rpub_ff;
      lchg_in       = lchg_ff;
      rchg_in       = rchg_ff;
      cpos_in       = cpos_ff;
      laccel_in     = laccel_ff;
      raccel_in     = raccel_ff;
      pending_in    = pending_ff;
      state_in      = state_ff;
      sel_in        = sel_ff;
      cnt_in        = cnt_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      lspeed_in     = lspeed_ff;
      rspeed_in     = rspeed_ff;
      gap_in        = gap_ff;

      lc      = correct_count(req_tdata[15:0], timer_mode_ff, wrap_thr_ff);
      rc      = correct_count(req_tdata[31:16], timer_mode_ff, wrap_thr_ff);
      lchg    = {8'b0, lsum_ff} - {8'b0, lpub_ff};
      rchg    = {8'b0, rsum_ff} - {8'b0, rpub_ff};
      sel_sum = sel_ff ? rsum_ff : lsum_ff;
      prod    = {16'b0, sel_sum} * {24'b0, perimeter_ff};
      d       = dvd_ff;
      r       = rem_ff;
      t       = '0;

      if (csr_fire) begin
         case (csr_index)
            CSR_TIMER_MODE: timer_mode_in = csr_data[0];
            CSR_WRAP_THR:   wrap_thr_in   = csr_data;
            CSR_PERIMETER:  perimeter_in  = csr_data;
            CSR_RATIO:      ratio_in      = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_SAMPLE)) begin
               lsum_in = lsum_ff - {8'b0, ltick_ff[tpos_ff]} + {8'b0, lc};
               rsum_in = rsum_ff - {8'b0, rtick_ff[tpos_ff]} + {8'b0, rc};
               ltick_in[tpos_ff] = lc;
               rtick_in[tpos_ff] = rc;
               if (tpos_ff == TICK_IDX_W'(TICK_WINDOW - 1)) begin
                  tpos_in = '0;
               end else begin
                  tpos_in = tpos_ff + 1'b1;
               end
               pending_in = 1'b1;
            end else if (req_fire && pending_ff) begin
               // The change ring sum is kept incrementally, like the tick sums.
               laccel_in = laccel_ff - lchg_ff[cpos_ff] + lchg;
               raccel_in = raccel_ff - rchg_ff[cpos_ff] + rchg;
               lchg_in[cpos_ff] = lchg;
               rchg_in[cpos_ff] = rchg;
               if (cpos_ff == ACCEL_IDX_W'(ACCEL_WINDOW - 1)) begin
                  cpos_in = '0;
               end else begin
                  cpos_in = cpos_ff + 1'b1;
               end
               lpub_in    = lsum_ff;
               rpub_in    = rsum_ff;
               gap_in     = (lsum_ff > rsum_ff) ? GAP_W'(lsum_ff - rsum_ff)
                                                : GAP_W'(rsum_ff - lsum_ff);
               pending_in = 1'b0;
               sel_in     = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            dvd_in   = prod[31:0];
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Restoring division; the quotient bits shift in behind the dividend.
            // A zero divisor always subtracts and so gives all ones.
            for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
               t = {r, d[WORD_W-1]};
               d = {d[WORD_W-2:0], 1'b0};
               if (t >= {1'b0, ratio_ff}) begin
                  t    = t - {1'b0, ratio_ff};
                  d[0] = 1'b1;
               end
               r = t[CFG_W-1:0];
            end
            dvd_in = d;
            rem_in = r;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               if (sel_ff) begin
                  rspeed_in = d;
                  state_in  = ST_DONE;
               end else begin
                  lspeed_in = d;
                  sel_in    = 1'b1;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff <= 1'b1;
         wrap_thr_ff   <= CFG_W'(32767);
         perimeter_ff  <= CFG_W'(1);
         ratio_ff      <= CFG_W'(1);
         for (int i = 0; i < TICK_WINDOW; i++) begin
            ltick_ff[i] <= '0;
            rtick_ff[i] <= '0;
         end
         for (int i = 0; i < ACCEL_WINDOW; i++) begin
            lchg_ff[i] <= '0;
            rchg_ff[i] <= '0;
         end
         tpos_ff    <= '0;
         cpos_ff    <= '0;
         lsum_ff    <= '0;
         rsum_ff    <= '0;
         lpub_ff    <= '0;
         rpub_ff    <= '0;
         laccel_ff  <= '0;
         raccel_ff  <= '0;
         pending_ff <= 1'b0;
         state_ff   <= ST_IDLE;
         sel_ff     <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         timer_mode_ff <= timer_mode_in;
         wrap_thr_ff   <= wrap_thr_in;
         perimeter_ff  <= perimeter_in;
         ratio_ff      <= ratio_in;
         ltick_ff      <= ltick_in;
         rtick_ff      <= rtick_in;
         lchg_ff       <= lchg_in;
         rchg_ff       <= rchg_in;
         tpos_ff       <= tpos_in;
         cpos_ff       <= cpos_in;
         lsum_ff       <= lsum_in;
         rsum_ff       <= rsum_in;
         lpub_ff       <= lpub_in;
         rpub_ff       <= rpub_in;
         laccel_ff     <= laccel_in;
         raccel_ff     <= raccel_in;
         pending_ff    <= pending_in;
         state_ff      <= state_in;
         sel_ff        <= sel_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      lspeed_ff <= lspeed_in;
      rspeed_ff <= rspeed_in;
      gap_ff    <= gap_in;
   end

endmodule
